FILE: rtl/iff_pkg.sv
// Shared types, codes and helper functions for the integer field formatter.
// No dependencies; every other file in rtl/ imports this package.
package iff_pkg;

   // Request and response payloads
   typedef struct packed {
      logic [63:0] raw_value;
      logic [1:0]  size_mode;
      logic [2:0]  conversion;
      logic [1:0]  sign_mode;
      logic        left_justify;
      logic        alternate_form;
      logic        zero_pad;
      logic [6:0]  field_width;
      logic        precision_given;
      logic [5:0]  precision;
   } iff_req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
      logic       empty_res;
   } iff_rsp_type;

   // Operand size codes
   localparam logic [1:0] SIZE_INT   = 2'd0;
   localparam logic [1:0] SIZE_SHORT = 2'd1;
   localparam logic [1:0] SIZE_LONG  = 2'd2;

   // Conversion codes
   localparam logic [2:0] CONV_SDEC       = 3'd0;
   localparam logic [2:0] CONV_UDEC       = 3'd1;
   localparam logic [2:0] CONV_OCT        = 3'd2;
   localparam logic [2:0] CONV_HEX_LOWER  = 3'd3;
   localparam logic [2:0] CONV_HEX_UPPER  = 3'd4;

   // Sign mode codes
   localparam logic [1:0] SIGN_NONE  = 2'd0;
   localparam logic [1:0] SIGN_SPACE = 2'd1;
   localparam logic [1:0] SIGN_PLUS  = 2'd2;

   // ASCII characters
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_A_UPPER = 8'h41;
   localparam logic [7:0] CHAR_X_UPPER = 8'h58;
   localparam logic [7:0] CHAR_A_LOWER = 8'h61;
   localparam logic [7:0] CHAR_X_LOWER = 8'h78;
   localparam logic [7:0] CHAR_NUL     = 8'h00;

   // Digit store and decimal converter geometry
   localparam int DIGIT_DEPTH   = 22;
   localparam int DIGIT_IDX_W   = 5;
   localparam int DIGIT_BITS    = DIGIT_DEPTH * 4;
   localparam int CONV_STEPS    = 32;   // two magnitude bits per step
   localparam int QUEUE_DEPTH   = 2;

   typedef logic [DIGIT_DEPTH-1:0][3:0] digit_vec_type;

   typedef enum logic [1:0] {
      BASE_DEC,
      BASE_OCT,
      BASE_HEX
   } iff_base_type;

   // One classified request, passed from the front end to the back end
   typedef struct packed {
      logic [63:0]  mag;
      logic         mag_zero;
      iff_base_type base;
      logic         upper;
      logic         alt;
      logic         left;
      logic         zflag;
      logic [6:0]   width;
      logic         pgiven;
      logic [5:0]   prec;
      logic [1:0]   plen;
      logic [7:0]   pre0;
      logic [7:0]   pre1;
   } iff_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } iff_qstat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_COUNT,
      ST_PLAN,
      ST_EMIT
   } iff_state_type;

   // One shift-and-add-3 step of the binary to BCD converter
   function automatic digit_vec_type dabble(input digit_vec_type d, input logic b);
      digit_vec_type           adj;
      logic [DIGIT_BITS-1:0]   flat;
      for (int i = 0; i < DIGIT_DEPTH; i++) begin
         adj[i] = (d[i] >= 4'd5) ? d[i] + 4'd3 : d[i];
      end
      flat = adj;
      return {flat[DIGIT_BITS-2:0], b};
   endfunction

   // Map one digit value to its ASCII character
   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] base_char;
      base_char = upper ? CHAR_A_UPPER : CHAR_A_LOWER;
      if (d < 4'd10) begin
         return CHAR_ZERO + {4'b0000, d};
      end
      return base_char + {4'b0000, d} - 8'd10;
   endfunction

endpackage

FILE: rtl/iff_front.sv
// Front end: accepts requests, sign-extends and classifies them into jobs.
// Depends on iff_pkg; pushes into iff_queue.
module iff_front
   import iff_pkg::*;
#(
   parameter int MAX_PRECISION = 63
) (
   input  logic          req_valid,
   output logic          req_ready,
   input  iff_req_type   req_payload,
   input  iff_qstat_type q_status,
   output logic          push,
   output iff_job_type   job
);

   logic [63:0] v;
   logic [63:0] zmag;
   logic [63:0] mag;
   logic [2:0]  conv;
   logic        is_signed;
   logic        neg;
   logic        mag_zero;
   logic        upper;
   iff_base_type base;

   // Accept whenever the queue has room
   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   // Sign-extend and zero-extend the argument for its size
   always_comb begin
      case (req_payload.size_mode)
         SIZE_SHORT: begin
            v    = {{48{req_payload.raw_value[15]}}, req_payload.raw_value[15:0]};
            zmag = {48'b0, req_payload.raw_value[15:0]};
         end
         SIZE_INT: begin
            v    = {{32{req_payload.raw_value[31]}}, req_payload.raw_value[31:0]};
            zmag = {32'b0, req_payload.raw_value[31:0]};
         end
         default: begin
            v    = req_payload.raw_value;
            zmag = req_payload.raw_value;
         end
      endcase
   end

   // Classify the conversion; unknown codes act as unsigned decimal
   always_comb begin
      conv = (req_payload.conversion > CONV_HEX_UPPER) ? CONV_UDEC : req_payload.conversion;
      is_signed = (conv == CONV_SDEC);
      upper     = (conv == CONV_HEX_UPPER);
      case (conv)
         CONV_OCT:                       base = BASE_OCT;
         CONV_HEX_LOWER, CONV_HEX_UPPER: base = BASE_HEX;
         default:                        base = BASE_DEC;
      endcase
      neg      = is_signed && v[63];
      mag      = neg ? 64'd0 - v : (is_signed ? v : zmag);
      mag_zero = (mag == 64'd0);
   end

   // Build the job, including sign or prefix characters
   always_comb begin
      job        = '0;
      job.mag    = mag;
      job.mag_zero = mag_zero;
      job.base   = base;
      job.upper  = upper;
      job.alt    = req_payload.alternate_form;
      job.left   = req_payload.left_justify;
      job.zflag  = req_payload.zero_pad;
      job.width  = req_payload.field_width;
      job.pgiven = req_payload.precision_given;
      job.prec   = (req_payload.precision > 6'(MAX_PRECISION)) ?
                   6'(MAX_PRECISION) : req_payload.precision;
      job.pre0   = CHAR_NUL;
      job.pre1   = CHAR_NUL;
      job.plen   = 2'd0;
      if (neg) begin
         job.plen = 2'd1;
         job.pre0 = CHAR_MINUS;
      end else if (is_signed && req_payload.sign_mode != SIGN_NONE) begin
         job.plen = 2'd1;
         job.pre0 = (req_payload.sign_mode == SIGN_SPACE) ? CHAR_SPACE : CHAR_PLUS;
      end else if (base == BASE_HEX && req_payload.alternate_form && !mag_zero) begin
         job.plen = 2'd2;
         job.pre0 = CHAR_ZERO;
         job.pre1 = upper ? CHAR_X_UPPER : CHAR_X_LOWER;
      end
   end

endmodule

FILE: rtl/iff_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on iff_pkg for the job and status types.
module iff_queue
   import iff_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  iff_job_type   push_data,
   input  logic          pop,
   output iff_job_type   pop_data,
   output iff_qstat_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   iff_job_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   assign status.full  = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/iff_back.sv
// Back end: converts the magnitude to digits, lays out the field and emits it
// via an output register, one character per cycle unless stalled. Uses iff_pkg.
module iff_back
   import iff_pkg::*;
#(
   parameter int MAX_FIELD_CHARS = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  iff_qstat_type q_status,
   input  iff_job_type   q_data,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output iff_rsp_type   rsp_payload
);

   localparam int POS_W = $clog2(MAX_FIELD_CHARS);

   iff_state_type   state_ff, state_in;
   iff_job_type     job_ff, job_in;
   logic [63:0]     remaining_value_ff, remaining_value_in;
   digit_vec_type   digits_ff, digits_in;
   logic [4:0]      conv_cnt_ff, conv_cnt_in;
   logic [4:0]      digit_count_ff, digit_count_in;
   logic [7:0]      b_lead_ff, b_lead_in;
   logic [7:0]      b_pre_ff, b_pre_in;
   logic [7:0]      b_zero_ff, b_zero_in;
   logic [7:0]      b_dig_ff, b_dig_in;
   logic [7:0]      n_out_ff, n_out_in;
   logic [POS_W-1:0] emit_position_ff, emit_position_in;
   logic            rsp_valid_ff, rsp_valid_in;
   iff_rsp_type     rsp_ff, rsp_in;

   digit_vec_type   load_digits;
   logic [4:0]      nd_enc;
   logic [7:0]      nd8, plen8, width8, prec8;
   logic [7:0]      zeros, body, spaces, total, lead;
   logic [7:0]      p8, dig_off;
   logic [DIGIT_IDX_W-1:0] dig_idx;
   logic [7:0]      emit_char;
   logic            emit_last;
   logic            slot_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign slot_free   = !rsp_valid_ff || rsp_ready;

   // Slice octal or hex digits straight from the queued magnitude
   always_comb begin
      load_digits = '0;
      if (q_data.base == BASE_OCT) begin
         for (int i = 0; i < DIGIT_DEPTH - 1; i++) begin
            load_digits[i] = {1'b0, q_data.mag[3*i +: 3]};
         end
         load_digits[DIGIT_DEPTH-1] = {3'b000, q_data.mag[63]};
      end else begin
         for (int i = 0; i < 16; i++) begin
            load_digits[i] = q_data.mag[4*i +: 4];
         end
      end
   end

   // Top non-zero digit; a zero value keeps one digit, none at precision 0
   always_comb begin
      nd_enc = 5'd1;
      for (int i = 0; i < DIGIT_DEPTH; i++) begin
         if (digits_ff[i] != 4'd0) begin
            nd_enc = 5'(i + 1);
         end
      end
      if (job_ff.mag_zero && job_ff.pgiven && job_ff.prec == 6'd0) begin
         nd_enc = 5'd0;
      end
   end

   // Lay out the field: spaces, prefix, zeros, digits, trailing spaces
   always_comb begin
      nd8    = {3'b000, digit_count_ff};
      plen8  = {6'b0, job_ff.plen};
      width8 = {1'b0, job_ff.width};
      prec8  = {2'b00, job_ff.prec};
      zeros  = 8'd0;
      if (job_ff.pgiven) begin
         if (prec8 > nd8) begin
            zeros = prec8 - nd8;
         end
      end else if (job_ff.zflag && !job_ff.left) begin
         if (width8 > nd8 + plen8) begin
            zeros = width8 - nd8 - plen8;
         end
      end
      // Octal alternate form needs a leading zero unless one is printed
      if (job_ff.base == BASE_OCT && job_ff.alt && zeros == 8'd0 &&
          !(digit_count_ff == 5'd1 && job_ff.mag_zero)) begin
         zeros = 8'd1;
      end
      body   = plen8 + zeros + nd8;
      spaces = (width8 > body) ? width8 - body : 8'd0;
      total  = body + spaces;
      lead   = job_ff.left ? 8'd0 : spaces;
   end

   // Pick the character at the current position
   always_comb begin
      p8        = {{(8-POS_W){1'b0}}, emit_position_ff};
      dig_off   = b_dig_ff - 8'd1 - p8;
      dig_idx   = dig_off[DIGIT_IDX_W-1:0];
      emit_last = (p8 == n_out_ff - 8'd1);
      if (p8 < b_lead_ff) begin
         emit_char = CHAR_SPACE;
      end else if (p8 < b_pre_ff) begin
         emit_char = (p8 == b_lead_ff) ? job_ff.pre0 : job_ff.pre1;
      end else if (p8 < b_zero_ff) begin
         emit_char = CHAR_ZERO;
      end else if (p8 < b_dig_ff) begin
         emit_char = digit_char(digits_ff[dig_idx], job_ff.upper);
      end else begin
         emit_char = CHAR_SPACE;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               state_in = (q_data.base == BASE_DEC) ? ST_CONV : ST_COUNT;
            end
         end
         ST_CONV: begin
            if (conv_cnt_ff == 5'd0) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: state_in = ST_PLAN;
         ST_PLAN:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (slot_free && (n_out_ff == 8'd0 || emit_last)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      pop                = 1'b0;
      job_in             = job_ff;
      remaining_value_in = remaining_value_ff;
      digits_in          = digits_ff;
      conv_cnt_in        = conv_cnt_ff;
      digit_count_in     = digit_count_ff;
      b_lead_in          = b_lead_ff;
      b_pre_in           = b_pre_ff;
      b_zero_in          = b_zero_ff;
      b_dig_in           = b_dig_ff;
      n_out_in           = n_out_ff;
      emit_position_in   = emit_position_ff;
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_ready ? 1'b0 : rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop                = 1'b1;
               job_in             = q_data;
               remaining_value_in = q_data.mag;
               conv_cnt_in        = 5'(CONV_STEPS - 1);
               digits_in          = (q_data.base == BASE_DEC) ? '0 : load_digits;
            end
         end
         ST_CONV: begin
            // Shift two magnitude bits into the BCD digits
            digits_in = dabble(dabble(digits_ff, remaining_value_ff[63]),
                               remaining_value_ff[62]);
            remaining_value_in = {remaining_value_ff[61:0], 2'b00};
            conv_cnt_in        = conv_cnt_ff - 5'd1;
         end
         ST_COUNT: begin
            digit_count_in = nd_enc;
         end
         ST_PLAN: begin
            b_lead_in        = lead;
            b_pre_in         = lead + plen8;
            b_zero_in        = lead + plen8 + zeros;
            b_dig_in         = lead + plen8 + zeros + nd8;
            n_out_in         = (total > 8'(MAX_FIELD_CHARS)) ? 8'(MAX_FIELD_CHARS) : total;
            emit_position_in = '0;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (n_out_ff == 8'd0) begin
                  rsp_in.character = CHAR_NUL;
                  rsp_in.last      = 1'b1;
                  rsp_in.empty_res = 1'b1;
               end else begin
                  rsp_in.character = emit_char;
                  rsp_in.last      = emit_last;
                  rsp_in.empty_res = 1'b0;
                  emit_position_in = emit_position_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      job_ff             <= job_in;
      remaining_value_ff <= remaining_value_in;
      digits_ff          <= digits_in;
      conv_cnt_ff        <= conv_cnt_in;
      digit_count_ff     <= digit_count_in;
      b_lead_ff          <= b_lead_in;
      b_pre_ff           <= b_pre_in;
      b_zero_ff          <= b_zero_in;
      b_dig_ff           <= b_dig_in;
      n_out_ff           <= n_out_in;
      emit_position_ff   <= emit_position_in;
      rsp_ff             <= rsp_in;
   end

endmodule

FILE: rtl/integer_field_formatter_unit.sv
// Top level of the integer field formatter: front end, job queue, back end.
// Depends on iff_pkg, iff_front, iff_queue and iff_back.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_ready   iff_req_type: one integer conversion
//   rsp_     out        rsp_valid/rsp_ready   iff_rsp_type: one character, last, empty
//
// A decimal request first passes the binary to BCD converter in 32 steps, two
// bits per cycle; octal and hex digits are sliced straight from the magnitude.
// The back end emits n = max(1, min(field length, MAX_FIELD_CHARS)) characters
// via an output register. The two-entry queue takes further requests while the back
// end works. A stalled rsp_ready holds the output register and the back end.
// Reset is synchronous and clears the queue, state machine and output valid.
module integer_field_formatter_unit
   import iff_pkg::*;
#(
   parameter int MAX_FIELD_CHARS = 64,
   parameter int MAX_PRECISION   = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  iff_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output iff_rsp_type rsp_payload
);

   iff_qstat_type q_status;
   iff_job_type   push_job;
   iff_job_type   pop_job;
   logic          push;
   logic          pop;

   // Classify incoming requests
   iff_front #(
      .MAX_PRECISION (MAX_PRECISION)
   ) u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .job         (push_job)
   );

   // Decouple front and back
   iff_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .pop_data  (pop_job),
      .status    (q_status)
   );

   // Convert and emit
   iff_back #(
      .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .q_data      (pop_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for integer_field_formatter_unit: directed table, then random requests.
// Depends on iff_pkg for payload types and codes; checks characters against text or a predictor.
module testbench
   import iff_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_FIELD_CHARS = 64;
   localparam int RANDOM_ITEMS    = 400;
   localparam int HOLD_CYCLES     = 128;
   localparam int STALL_LIMIT     = 4000;
   localparam int PRINT_LIMIT     = 200;

   // Codes beyond the defined ones, which the block must fold onto defined ones
   localparam logic [1:0] SIZE_SPARE = 2'd3;
   localparam logic [2:0] CONV_SPARE = 3'd7;
   localparam logic [1:0] SIGN_SPARE = 2'd3;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   iff_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   iff_rsp_type rsp_payload;

   iff_rsp_type pending_chars [$];
   iff_req_type plan_req [$];
   string       plan_text [$];
   bit          plan_typed [$];

   bit          steady       = 1'b0;
   int          errors       = 0;
   int          requests     = 0;
   int          chars_seen   = 0;
   int          empty_seen   = 0;
   int          cut_fields   = 0;
   int          quiet_cycles = 0;
   iff_rsp_type want_rsp;

   integer_field_formatter_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= PRINT_LIMIT) begin
         $display("mismatch at %0t: %s", $realtime, what);
      end
   endtask

   function automatic logic [7:0] glyph_of(input logic [3:0] d, input bit upper);
      if (d < 4'd10) begin
         return CHAR_ZERO + {4'd0, d};
      end
      return (upper ? CHAR_A_UPPER : CHAR_A_LOWER) + {4'd0, d} - 8'd10;
   endfunction

   // Queue a literal field, or the single empty marker when the text is blank
   task automatic expect_text(input string s);
      iff_rsp_type item;
      int          i;
      if (s.len() == 0) begin
         item = '{character: CHAR_NUL, last: 1'b1, empty_res: 1'b1};
         pending_chars.push_back(item);
      end else begin
         for (i = 0; i < s.len(); i++) begin
            item = '{character: s[i], last: (i == s.len() - 1), empty_res: 1'b0};
            pending_chars.push_back(item);
         end
      end
   endtask

   // Form the field for one conversion request and queue its characters
   task automatic predict_field(input iff_req_type r);
      logic [63:0] sized, mag, rest, radix, rem_digit;
      logic [3:0]  digit_buf [0:DIGIT_DEPTH-1];
      logic [2:0]  conv;
      logic [7:0]  lead [0:1];
      logic [7:0]  text [$];
      iff_rsp_type item;
      bit          neg, upper, signed_conv;
      int          nd, plen, zeros, body, spaces, width, prec, i;
      neg         = 1'b0;
      upper       = 1'b0;
      signed_conv = 1'b0;
      nd          = 0;
      plen        = 0;
      zeros       = 0;
      width       = r.field_width;
      prec        = r.precision;
      conv        = (r.conversion > CONV_HEX_UPPER) ? CONV_UDEC : r.conversion;

      case (r.size_mode)
         SIZE_SHORT: sized = {{48{r.raw_value[15]}}, r.raw_value[15:0]};
         SIZE_INT:   sized = {{32{r.raw_value[31]}}, r.raw_value[31:0]};
         default:    sized = r.raw_value;
      endcase

      // Take magnitude and base from the conversion
      if (conv == CONV_SDEC) begin
         signed_conv = 1'b1;
         radix       = 64'd10;
         neg         = sized[63];
         mag         = neg ? (64'd0 - sized) : sized;
      end else begin
         case (r.size_mode)
            SIZE_SHORT: mag = {48'd0, r.raw_value[15:0]};
            SIZE_INT:   mag = {32'd0, r.raw_value[31:0]};
            default:    mag = r.raw_value;
         endcase
         radix = (conv == CONV_OCT) ? 64'd8 : (conv == CONV_UDEC) ? 64'd10 : 64'd16;
         upper = (conv == CONV_HEX_UPPER);
      end

      // Split into digits, least significant first
      rest = mag;
      do begin
         rem_digit     = rest % radix;
         digit_buf[nd] = rem_digit[3:0];
         rest          = rest / radix;
         nd++;
      end while (rest != 0 && nd < DIGIT_DEPTH);
      if (mag == 0 && r.precision_given && prec == 0) begin
         nd = 0;
      end

      // Sign, plus or space, else hex prefix for a non-zero value
      if (neg) begin
         lead[0] = CHAR_MINUS;
         plen    = 1;
      end else if (signed_conv && r.sign_mode != SIGN_NONE) begin
         lead[0] = (r.sign_mode == SIGN_SPACE) ? CHAR_SPACE : CHAR_PLUS;
         plen    = 1;
      end else if (radix == 64'd16 && r.alternate_form && mag != 0) begin
         lead[0] = CHAR_ZERO;
         lead[1] = upper ? CHAR_X_UPPER : CHAR_X_LOWER;
         plen    = 2;
      end

      // Zeros from precision, else from the zero flag counting the prefix
      if (r.precision_given) begin
         if (prec > nd) zeros = prec - nd;
      end else if (r.zero_pad && !r.left_justify) begin
         if (width - nd - plen > 0) zeros = width - nd - plen;
      end
      if (radix == 64'd8 && r.alternate_form && zeros == 0 && !(nd == 1 && mag == 0)) begin
         zeros = 1;
      end
      body   = plen + zeros + nd;
      spaces = (width > body) ? width - body : 0;

      if (!r.left_justify) repeat (spaces) text.push_back(CHAR_SPACE);
      for (i = 0; i < plen; i++) text.push_back(lead[i]);
      repeat (zeros) text.push_back(CHAR_ZERO);
      for (i = nd - 1; i >= 0; i--) text.push_back(glyph_of(digit_buf[i], upper));
      if (r.left_justify) repeat (spaces) text.push_back(CHAR_SPACE);

      // Cut long fields, then queue
      if (text.size() > MAX_FIELD_CHARS) cut_fields++;
      while (text.size() > MAX_FIELD_CHARS) void'(text.pop_back());
      if (text.size() == 0) begin
         item = '{character: CHAR_NUL, last: 1'b1, empty_res: 1'b1};
         pending_chars.push_back(item);
      end else begin
         for (i = 0; i < text.size(); i++) begin
            item = '{character: text[i], last: (i == text.size() - 1), empty_res: 1'b0};
            pending_chars.push_back(item);
         end
      end
   endtask

   function automatic iff_req_type conversion_of(
      input logic [63:0] raw, input logic [1:0] size, input logic [2:0] conv,
      input logic [1:0] sign, input int left, input int alt, input int zpad,
      input int width, input int pgiven, input int prec);
      iff_req_type r;
      r.raw_value       = raw;
      r.size_mode       = size;
      r.conversion      = conv;
      r.sign_mode       = sign;
      r.left_justify    = left[0];
      r.alternate_form  = alt[0];
      r.zero_pad        = zpad[0];
      r.field_width     = width[6:0];
      r.precision_given = pgiven[0];
      r.precision       = prec[5:0];
      return r;
   endfunction

   task automatic add_case(input iff_req_type r, input int typed, input string s);
      plan_req.push_back(r);
      plan_typed.push_back(typed[0]);
      plan_text.push_back(s);
   endtask

   // Directed table: literal fields where obvious, predictor elsewhere
   task automatic build_plan();
      add_case(conversion_of(64'd0, SIZE_INT, CONV_SDEC, SIGN_NONE, 0, 0, 0, 0, 0, 0), 1, "0");
      add_case(conversion_of(64'd0, SIZE_INT, CONV_UDEC, SIGN_NONE, 0, 0, 0, 0, 1, 0), 1, "");
      add_case(conversion_of(64'd0, SIZE_INT, CONV_SDEC, SIGN_PLUS, 0, 0, 0, 0, 1, 0), 1, "+");
      add_case(conversion_of(64'h0000_0000_8000_0000, SIZE_INT, CONV_SDEC, SIGN_NONE,
                             0, 0, 0, 0, 0, 0), 1, "-2147483648");
      add_case(conversion_of(64'hFFFF_FFFF_FFFF_8000, SIZE_SHORT, CONV_SDEC, SIGN_NONE,
                             0, 0, 0, 0, 0, 0), 1, "-32768");
      add_case(conversion_of(64'h8000_0000_0000_0000, SIZE_LONG, CONV_SDEC, SIGN_NONE,
                             0, 0, 0, 0, 0, 0), 1, "-9223372036854775808");
      add_case(conversion_of('1, SIZE_LONG, CONV_UDEC, SIGN_NONE, 0, 0, 0, 0, 0, 0),
               1, "18446744073709551615");
      add_case(conversion_of('1, SIZE_LONG, CONV_HEX_UPPER, SIGN_NONE, 0, 1, 0, 0, 0, 0),
               1, "0XFFFFFFFFFFFFFFFF");
      add_case(conversion_of('1, SIZE_LONG, CONV_OCT, SIGN_NONE, 0, 0, 0, 0, 0, 0),
               1, "1777777777777777777777");
      add_case(conversion_of(64'd0, SIZE_INT, CONV_HEX_LOWER, SIGN_NONE, 0, 1, 0, 0, 0, 0), 1, "0");
      add_case(conversion_of(64'd8, SIZE_INT, CONV_OCT, SIGN_NONE, 0, 1, 0, 0, 0, 0), 1, "010");
      add_case(conversion_of(64'd0, SIZE_INT, CONV_OCT, SIGN_NONE, 0, 1, 0, 0, 0, 0), 1, "0");
      add_case(conversion_of('1, SIZE_SHORT, CONV_UDEC, SIGN_NONE, 0, 0, 0, 0, 0, 0), 1, "65535");
      add_case(conversion_of(64'd42, SIZE_INT, CONV_SDEC, SIGN_PLUS, 0, 0, 1, 10, 0, 0), 0, "");
      add_case(conversion_of(64'hFFFF_FFFB, SIZE_INT, CONV_SDEC, SIGN_NONE, 0, 0, 1, 8, 1, 3),
               0, "");
      add_case(conversion_of(64'hBEEF, SIZE_INT, CONV_HEX_LOWER, SIGN_NONE, 0, 1, 1, 12, 0, 0),
               0, "");
      add_case(conversion_of(64'd7, SIZE_INT, CONV_UDEC, SIGN_SPACE, 1, 0, 0, 64, 0, 0), 0, "");
      add_case(conversion_of('1, SIZE_LONG, CONV_SDEC, SIGN_NONE, 0, 0, 0, 127, 0, 0), 0, "");
      add_case(conversion_of('1, SIZE_LONG, CONV_HEX_UPPER, SIGN_NONE, 0, 1, 0, 0, 1, 63), 0, "");
      add_case(conversion_of(64'h8000_0000_0000_0001, SIZE_SPARE, CONV_SDEC, SIGN_NONE,
                             0, 0, 0, 0, 0, 0), 0, "");
      add_case(conversion_of(64'h1234_5678_9ABC_DEF0, SIZE_LONG, CONV_SPARE, SIGN_PLUS,
                             0, 1, 0, 0, 0, 0), 0, "");
      add_case(conversion_of(64'd123, SIZE_INT, CONV_SDEC, SIGN_SPARE, 0, 0, 0, 6, 0, 0), 0, "");
      add_case(conversion_of(64'd8, SIZE_INT, CONV_OCT, SIGN_NONE, 0, 1, 0, 0, 1, 5), 0, "");
      add_case(conversion_of(64'd0, SIZE_INT, CONV_SDEC, SIGN_SPACE, 0, 0, 0, 5, 1, 0), 0, "");
      add_case(conversion_of(64'hABC, SIZE_INT, CONV_HEX_UPPER, SIGN_NONE, 1, 1, 1, 9, 0, 0),
               0, "");
   endtask

   function automatic iff_req_type random_request();
      iff_req_type r;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         r.raw_value = 64'($urandom_range(0, 20));
      end else if (pick == 2) begin
         case ($urandom_range(0, 4))
            0:       r.raw_value = '0;
            1:       r.raw_value = '1;
            2:       r.raw_value = 64'h8000_0000_0000_0000;
            3:       r.raw_value = 64'h0000_0000_8000_0000;
            default: r.raw_value = 64'h0000_0000_0000_8000;
         endcase
      end else begin
         r.raw_value = {$urandom, $urandom};
      end
      r.size_mode       = 2'($urandom_range(0, 3));
      r.conversion      = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                      : 3'($urandom_range(0, 4));
      r.sign_mode       = 2'($urandom_range(0, 3));
      r.left_justify    = 1'($urandom_range(0, 1));
      r.alternate_form  = 1'($urandom_range(0, 1));
      r.zero_pad        = 1'($urandom_range(0, 1));
      r.field_width     = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                      : 7'($urandom_range(0, 24));
      r.precision_given = 1'($urandom_range(0, 1));
      r.precision       = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                      : 6'($urandom_range(0, 12));
      return r;
   endfunction

   // Offer one request from a falling edge; hold it until accepted
   task automatic send_request(input iff_req_type r, input bit typed, input string s);
      if (!steady) begin
         while ($urandom_range(0, 99) < 8) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      end
      req_payload = r;
      req_valid   = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (typed) expect_text(s);
      else predict_field(r);
      requests++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every queued character has come out
   task automatic drain_and_hold();
      req_valid = 1'b0;
      while (pending_chars.size() != 0) @(negedge clock);
      repeat (HOLD_CYCLES) @(negedge clock);
   endtask

   // Receiver stalls, none in the steady stretch
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 8);
   end

   // Check accepted characters and watch for lack of progress
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         chars_seen++;
         if (rsp_payload.empty_res) empty_seen++;
         if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h", rsp_payload.character));
         end else begin
            want_rsp = pending_chars.pop_front();
            if (rsp_payload.character !== want_rsp.character ||
                rsp_payload.last !== want_rsp.last ||
                rsp_payload.empty_res !== want_rsp.empty_res) begin
               report_mismatch($sformatf(
                  "request %0d: char 0x%02h last %0b empty %0b, wanted 0x%02h %0b %0b",
                  requests, rsp_payload.character, rsp_payload.last, rsp_payload.empty_res,
                  want_rsp.character, want_rsp.last, want_rsp.empty_res));
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d characters outstanding",
                  STALL_LIMIT, pending_chars.size());
         $display("FAIL integer_field_formatter_unit");
         $finish;
      end
   end

   initial begin
      int k;
      build_plan();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (k = 0; k < plan_req.size(); k++) begin
         send_request(plan_req[k], plan_typed[k], plan_text[k]);
      end
      drain_and_hold();

      for (k = 0; k < RANDOM_ITEMS; k++) begin
         steady = (k >= 150 && k < 250);
         if (k == 300) drain_and_hold();
         send_request(random_request(), 1'b0, "");
      end
      steady = 1'b0;
      drain_and_hold();

      if (pending_chars.size() != 0) begin
         report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
      end
      $display("run covered %0d requests (%0d from the table) and %0d characters,",
               requests, plan_req.size(), chars_seen);
      $display("  %0d empty fields and %0d fields cut at %0d characters; %0d mismatches",
               empty_seen, cut_fields, MAX_FIELD_CHARS, errors);
      if (errors == 0) begin
         $display("PASS integer_field_formatter_unit");
      end else begin
         $display("FAIL integer_field_formatter_unit");
      end
      $finish;
   end

endmodule
